>>> design/abt_pkg.sv
package abt_pkg;

    // Number formats.
    localparam int FRAC_BITS  = 16;
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int COEF_W     = 20;
    localparam int COEF_FRAC  = 16;
    localparam int TRANS_W    = 25;
    localparam int TRANS_FRAC = 8;
    localparam int PROD_FRAC  = FRAC_BITS + COEF_FRAC;
    localparam int NORM_W     = FRAC_BITS;
    localparam int SIZE_W     = FRAC_BITS + 1;
    localparam int PIX_W      = SIZE_W + DIM_W;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int COORD_W    = ACC_W - PROD_FRAC;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int LABEL_W    = 16;

    // Divider pipeline: quotient bits resolved per stage.
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS;

    // Pipeline: four front stages, the divider, and the output register.
    localparam int FRONT_STAGES = 4;
    localparam int N_STAGES     = FRONT_STAGES + DIV_STAGES + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_M00          = 4'd0,
        REG_M01          = 4'd1,
        REG_M02          = 4'd2,
        REG_M10          = 4'd3,
        REG_M11          = 4'd4,
        REG_M12          = 4'd5,
        REG_IMAGE_WIDTH  = 4'd6,
        REG_IMAGE_HEIGHT = 4'd7
    } cfg_reg_t;

    // Enables for the divider stages, handed down from the top level.
    typedef struct packed {
        logic [DIV_STAGES-1:0] en;
    } div_ctrl_t;

    // Drop the product fraction, rounding toward zero.
    function automatic logic signed [COORD_W-1:0] trunc_coord(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] biased;
        biased = acc + (acc[ACC_W-1] ? ACC_W'((64'd1 << PROD_FRAC) - 64'd1) : ACC_W'(0));
        return biased[ACC_W-1:PROD_FRAC];
    endfunction

    // Clamp a signed coordinate to [0, lim].
    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic signed [COORD_W-1:0] v,
        input logic [DIM_W-1:0]          lim
    );
        logic [DIM_W-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > $signed({{(COORD_W-DIM_W){1'b0}}, lim}))
            res = lim;
        else
            res = v[DIM_W-1:0];
        return res;
    endfunction

    // An image size of zero counts as one, above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            res = DIM_W'(MAX_DIM);
        else
            res = v;
        return res;
    endfunction

endpackage

>>> design/affine_bbox_transform_top.sv
// Channel  Handshake             Word
// in       in_valid / in_stall   label, norm_left, norm_top, norm_width, norm_height
// out      out_valid / out_stall kept, out_label, out_left, out_top, out_width, out_height
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word enters per cycle while in_stall is low. The pipeline holds four front stages,
// eight divider stages resolving two quotient bits each, and one output register.
// The divider pipeline sets the depth. Reset clears the valid bits and loads
// the register defaults. A stall holds only full stages: bubbles close up,
// and in_stall rises only when every stage holds a word and out is stalled.
module affine_bbox_transform_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [abt_pkg::LABEL_W-1:0]       label,
    input  logic [abt_pkg::NORM_W-1:0]        norm_left,
    input  logic [abt_pkg::NORM_W-1:0]        norm_top,
    input  logic [abt_pkg::SIZE_W-1:0]        norm_width,
    input  logic [abt_pkg::SIZE_W-1:0]        norm_height,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kept,
    output logic [abt_pkg::LABEL_W-1:0]       out_label,
    output logic [abt_pkg::Q_W-1:0]           out_left,
    output logic [abt_pkg::Q_W-1:0]           out_top,
    output logic [abt_pkg::Q_W-1:0]           out_width,
    output logic [abt_pkg::Q_W-1:0]           out_height,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [abt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int N  = abt_pkg::N_STAGES;
    localparam int DS = abt_pkg::DIV_STAGES;
    localparam int FS = abt_pkg::FRONT_STAGES;

    // Configuration registers.
    logic signed [abt_pkg::COEF_W-1:0]  m00_reg, m01_reg, m10_reg, m11_reg;
    logic signed [abt_pkg::TRANS_W-1:0] m02_reg, m12_reg;
    logic [abt_pkg::DIM_W-1:0]          image_width_reg, image_height_reg;
    logic [abt_pkg::DIM_W-1:0]          w_eff, h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m00_reg          <= abt_pkg::COEF_W'(65536);
            m01_reg          <= '0;
            m02_reg          <= '0;
            m10_reg          <= '0;
            m11_reg          <= abt_pkg::COEF_W'(65536);
            m12_reg          <= '0;
            image_width_reg  <= abt_pkg::DIM_W'(640);
            image_height_reg <= abt_pkg::DIM_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                abt_pkg::REG_M00:          m00_reg <= cfg_data[abt_pkg::COEF_W-1:0];
                abt_pkg::REG_M01:          m01_reg <= cfg_data[abt_pkg::COEF_W-1:0];
                abt_pkg::REG_M02:          m02_reg <= cfg_data[abt_pkg::TRANS_W-1:0];
                abt_pkg::REG_M10:          m10_reg <= cfg_data[abt_pkg::COEF_W-1:0];
                abt_pkg::REG_M11:          m11_reg <= cfg_data[abt_pkg::COEF_W-1:0];
                abt_pkg::REG_M12:          m12_reg <= cfg_data[abt_pkg::TRANS_W-1:0];
                abt_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[abt_pkg::DIM_W-1:0];
                abt_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[abt_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff = abt_pkg::dim_sat(image_width_reg);
    assign h_eff = abt_pkg::dim_sat(image_height_reg);

    // Valid bits and per-stage enables; a stage loads when empty or draining.
    logic [N-1:0] v_reg, v_next, en;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || !out_stall;
        for (int k = N - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
        for (int k = 0; k < N; k++)
        begin
            if (en[k])
                v_next[k] = (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            else
                v_next[k] = v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[N-1];

    // Stage 1: corner positions in pixels.
    logic [abt_pkg::PIX_W-1:0]   s1_xs0_reg, s1_xs1_reg, s1_ys0_reg, s1_ys1_reg;
    logic [abt_pkg::PIX_W-1:0]   s1_xs0_next, s1_xs1_next, s1_ys0_next, s1_ys1_next;
    logic [abt_pkg::SIZE_W-1:0]  x_end, y_end;
    logic                        s1_ok_reg, s1_ok_next;
    logic [abt_pkg::LABEL_W-1:0] s1_label_reg;

    always_comb
    begin
        x_end       = abt_pkg::SIZE_W'(norm_left) + norm_width;
        y_end       = abt_pkg::SIZE_W'(norm_top) + norm_height;
        s1_xs0_next = abt_pkg::PIX_W'(norm_left) * abt_pkg::PIX_W'(w_eff);
        s1_xs1_next = abt_pkg::PIX_W'(x_end) * abt_pkg::PIX_W'(w_eff);
        s1_ys0_next = abt_pkg::PIX_W'(norm_top) * abt_pkg::PIX_W'(h_eff);
        s1_ys1_next = abt_pkg::PIX_W'(y_end) * abt_pkg::PIX_W'(h_eff);
        s1_ok_next  = (norm_width != '0)
                   && (norm_width <= abt_pkg::SIZE_W'(1 << abt_pkg::FRAC_BITS))
                   && (norm_height != '0)
                   && (norm_height <= abt_pkg::SIZE_W'(1 << abt_pkg::FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_xs0_reg   <= s1_xs0_next;
            s1_xs1_reg   <= s1_xs1_next;
            s1_ys0_reg   <= s1_ys0_next;
            s1_ys1_reg   <= s1_ys1_next;
            s1_ok_reg    <= s1_ok_next;
            s1_label_reg <= label;
        end
    end

    // Stage 2: matrix products, one per coefficient and coordinate.
    logic signed [abt_pkg::PIX_W:0]    xs0_s, xs1_s, ys0_s, ys1_s;
    logic signed [abt_pkg::PROD_W-1:0] s2_ax_reg [2];
    logic signed [abt_pkg::PROD_W-1:0] s2_bx_reg [2];
    logic signed [abt_pkg::PROD_W-1:0] s2_ay_reg [2];
    logic signed [abt_pkg::PROD_W-1:0] s2_by_reg [2];
    logic                              s2_ok_reg;
    logic [abt_pkg::LABEL_W-1:0]       s2_label_reg;

    assign xs0_s = {1'b0, s1_xs0_reg};
    assign xs1_s = {1'b0, s1_xs1_reg};
    assign ys0_s = {1'b0, s1_ys0_reg};
    assign ys1_s = {1'b0, s1_ys1_reg};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_ax_reg[0] <= m00_reg * xs0_s;
            s2_ax_reg[1] <= m00_reg * xs1_s;
            s2_bx_reg[0] <= m01_reg * ys0_s;
            s2_bx_reg[1] <= m01_reg * ys1_s;
            s2_ay_reg[0] <= m10_reg * xs0_s;
            s2_ay_reg[1] <= m10_reg * xs1_s;
            s2_by_reg[0] <= m11_reg * ys0_s;
            s2_by_reg[1] <= m11_reg * ys1_s;
            s2_ok_reg    <= s1_ok_reg;
            s2_label_reg <= s1_label_reg;
        end
    end

    // Stage 3: four mapped corners, truncated toward zero.
    logic signed [abt_pkg::ACC_W-1:0]   tx_acc, ty_acc;
    logic signed [abt_pkg::COORD_W-1:0] s3_px_reg [4];
    logic signed [abt_pkg::COORD_W-1:0] s3_py_reg [4];
    logic signed [abt_pkg::COORD_W-1:0] s3_px_next [4];
    logic signed [abt_pkg::COORD_W-1:0] s3_py_next [4];
    logic                               s3_ok_reg;
    logic [abt_pkg::LABEL_W-1:0]        s3_label_reg;

    assign tx_acc = abt_pkg::ACC_W'(m02_reg) <<< (abt_pkg::PROD_FRAC - abt_pkg::TRANS_FRAC);
    assign ty_acc = abt_pkg::ACC_W'(m12_reg) <<< (abt_pkg::PROD_FRAC - abt_pkg::TRANS_FRAC);

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                s3_px_next[2*i+j] = abt_pkg::trunc_coord(abt_pkg::ACC_W'(s2_ax_reg[i])
                                    + abt_pkg::ACC_W'(s2_bx_reg[j]) + tx_acc);
                s3_py_next[2*i+j] = abt_pkg::trunc_coord(abt_pkg::ACC_W'(s2_ay_reg[i])
                                    + abt_pkg::ACC_W'(s2_by_reg[j]) + ty_acc);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_px_reg    <= s3_px_next;
            s3_py_reg    <= s3_py_next;
            s3_ok_reg    <= s2_ok_reg;
            s3_label_reg <= s2_label_reg;
        end
    end

    // Stage 4: bounding box, clamp to the image, extents.
    logic signed [abt_pkg::COORD_W-1:0] minx, maxx, miny, maxy;
    logic [abt_pkg::DIM_W-1:0]          cminx, cmaxx, cminy, cmaxy;
    logic [abt_pkg::DIM_W-1:0]          s4_nx_reg, s4_dx_reg, s4_ny_reg, s4_dy_reg;
    logic                               s4_ok_reg;
    logic [abt_pkg::LABEL_W-1:0]        s4_label_reg;

    always_comb
    begin
        minx = s3_px_reg[0];
        maxx = s3_px_reg[0];
        miny = s3_py_reg[0];
        maxy = s3_py_reg[0];
        for (int c = 1; c < 4; c++)
        begin
            if (s3_px_reg[c] < minx) minx = s3_px_reg[c];
            if (s3_px_reg[c] > maxx) maxx = s3_px_reg[c];
            if (s3_py_reg[c] < miny) miny = s3_py_reg[c];
            if (s3_py_reg[c] > maxy) maxy = s3_py_reg[c];
        end
        cminx = abt_pkg::clamp_dim(minx, w_eff);
        cmaxx = abt_pkg::clamp_dim(maxx, w_eff);
        cminy = abt_pkg::clamp_dim(miny, h_eff);
        cmaxy = abt_pkg::clamp_dim(maxy, h_eff);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_nx_reg    <= cminx;
            s4_dx_reg    <= cmaxx - cminx;
            s4_ny_reg    <= cminy;
            s4_dy_reg    <= cmaxy - cminy;
            s4_ok_reg    <= s3_ok_reg;
            s4_label_reg <= s3_label_reg;
        end
    end

    // Divider stages: four quotients side by side.
    abt_pkg::div_ctrl_t      div_ctrl;
    logic [abt_pkg::Q_W-1:0] q_x, q_w, q_y, q_h;

    assign div_ctrl.en = en[FS +: DS];

    abt_div u_div_x (.clk(clk), .ctrl(div_ctrl), .num(s4_nx_reg), .den(w_eff), .quot(q_x));
    abt_div u_div_w (.clk(clk), .ctrl(div_ctrl), .num(s4_dx_reg), .den(w_eff), .quot(q_w));
    abt_div u_div_y (.clk(clk), .ctrl(div_ctrl), .num(s4_ny_reg), .den(h_eff), .quot(q_y));
    abt_div u_div_h (.clk(clk), .ctrl(div_ctrl), .num(s4_dy_reg), .den(h_eff), .quot(q_h));

    // Label and size check ride alongside the divider.
    logic                        d_ok_reg    [DS];
    logic [abt_pkg::LABEL_W-1:0] d_label_reg [DS];

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DS; s++)
        begin
            if (en[FS+s])
            begin
                d_ok_reg[s]    <= (s == 0) ? s4_ok_reg    : d_ok_reg[(s == 0) ? 0 : s - 1];
                d_label_reg[s] <= (s == 0) ? s4_label_reg : d_label_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // Output register: center-based acceptance test.
    localparam logic [abt_pkg::Q_W+1:0] ONE_Q  = (abt_pkg::Q_W+2)'(1 << abt_pkg::FRAC_BITS);
    localparam logic [abt_pkg::Q_W+1:0] TWO_Q  = (abt_pkg::Q_W+2)'(2 << abt_pkg::FRAC_BITS);

    logic [abt_pkg::Q_W+1:0]   ex, ey, ew, eh;
    logic                      kept_next;
    logic                      kept_reg;
    logic [abt_pkg::LABEL_W-1:0] label_reg;
    logic [abt_pkg::Q_W-1:0]   left_reg, top_reg, width_reg, height_reg;

    always_comb
    begin
        ex = (abt_pkg::Q_W+2)'(q_x);
        ey = (abt_pkg::Q_W+2)'(q_y);
        ew = (abt_pkg::Q_W+2)'(q_w);
        eh = (abt_pkg::Q_W+2)'(q_h);
        kept_next = d_ok_reg[DS-1];
        if (ew == '0 || eh == '0 || ew > ONE_Q || eh > ONE_Q)
            kept_next = 1'b0;
        if ((ex << 1) < ew || (ey << 1) < eh)
            kept_next = 1'b0;
        if ((ex << 1) + ew >= TWO_Q || (ey << 1) + eh >= TWO_Q)
            kept_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en[N-1])
        begin
            kept_reg   <= kept_next;
            label_reg  <= d_label_reg[DS-1];
            left_reg   <= kept_next ? q_x : '0;
            top_reg    <= kept_next ? q_y : '0;
            width_reg  <= kept_next ? q_w : '0;
            height_reg <= kept_next ? q_h : '0;
        end
    end

    assign kept       = kept_reg;
    assign out_label  = label_reg;
    assign out_left   = left_reg;
    assign out_top    = top_reg;
    assign out_width  = width_reg;
    assign out_height = height_reg;

`ifndef SYNTHESIS
    // Input is held back only when every stage is full and out is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && (&v_reg)))
        else $error("input stalled with room in the pipeline");

    // A rejected box carries no geometry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kept) |-> (out_left == '0 && out_top == '0
                                  && out_width == '0 && out_height == '0))
        else $error("rejected box with nonzero geometry");

    // A kept box has a nonzero extent of at most one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kept) |-> (out_width != '0 && out_height != '0
            && out_width <= abt_pkg::Q_W'(1 << abt_pkg::FRAC_BITS)
            && out_height <= abt_pkg::Q_W'(1 << abt_pkg::FRAC_BITS)))
        else $error("kept box with bad extent");
`endif

endmodule

>>> design/abt_div.sv
// Pipelined restoring divider: q = floor(num * 2^FRAC_BITS / den) for num <= den.
module abt_div
(
    input  logic                          clk,
    input  abt_pkg::div_ctrl_t            ctrl,
    input  logic [abt_pkg::DIM_W-1:0]     num,
    input  logic [abt_pkg::DIM_W-1:0]     den,
    output logic [abt_pkg::Q_W-1:0]       quot
);

    logic [abt_pkg::DIM_W-1:0] r_reg [abt_pkg::DIV_STAGES];
    logic [abt_pkg::Q_W-1:0]   q_reg [abt_pkg::DIV_STAGES];

    // Integer quotient bit: set when num is at least den.
    logic                      init_bit;
    logic [abt_pkg::DIM_W-1:0] init_r;

    assign init_bit = (num >= den);
    assign init_r   = init_bit ? (num - den) : num;

    for (genvar s = 0; s < abt_pkg::DIV_STAGES; s++) begin : g_stage
        logic [abt_pkg::DIM_W-1:0] r_in;
        logic [abt_pkg::Q_W-1:0]   q_in;
        logic [abt_pkg::DIM_W-1:0] r_next;
        logic [abt_pkg::Q_W-1:0]   q_next;

        if (s == 0) begin : g_first
            assign r_in = init_r;
            assign q_in = abt_pkg::Q_W'(init_bit);
        end
        else begin : g_rest
            assign r_in = r_reg[s-1];
            assign q_in = q_reg[s-1];
        end

        // DIV_STEPS shift-and-subtract steps per stage.
        always_comb
        begin
            logic [abt_pkg::DIM_W:0] r2;
            r_next = r_in;
            q_next = q_in;
            for (int k = 0; k < abt_pkg::DIV_STEPS; k++)
            begin
                r2 = {r_next, 1'b0};
                if (r2 >= {1'b0, den})
                begin
                    r_next = abt_pkg::DIM_W'(r2 - {1'b0, den});
                    q_next = {q_next[abt_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = r2[abt_pkg::DIM_W-1:0];
                    q_next = {q_next[abt_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.en[s])
            begin
                r_reg[s] <= r_next;
                q_reg[s] <= q_next;
            end
        end
    end

    assign quot = q_reg[abt_pkg::DIV_STAGES-1];

endmodule
